/* design/bmp_pkg.sv */
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, constants and helpers of the banked memory paging unit:
// port decode masks, status codes, configuration layout and bank mapping.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // Bank numbering
    localparam int RAM_BANKS = 64;
    localparam int BANK_W    = 6;

    // Port decode: main port and secondary port
    localparam logic [15:0] MAIN_MASK   = 16'hC002;
    localparam logic [15:0] MAIN_MATCH  = 16'h4000;
    localparam logic [15:0] EXTRA_MASK  = 16'hF002;
    localparam logic [15:0] EXTRA_MATCH = 16'h1000;

    // Screen bank choices
    localparam logic [2:0] SCREEN_NORMAL = 3'd5;
    localparam logic [2:0] SCREEN_SHADOW = 3'd7;

    // Slot mapping after reset and on return to normal mapping
    localparam logic [BANK_W-1:0] SLOT0_RESET = 6'd0;
    localparam logic [BANK_W-1:0] SLOT1_RESET = 6'd5;
    localparam logic [BANK_W-1:0] SLOT2_RESET = 6'd2;
    localparam logic [BANK_W-1:0] SLOT3_RESET = 6'd0;

    // All-RAM layouts, indexed by secondary port bits 2..1, then by slot
    localparam logic [2:0] ALLRAM [4][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd4, 3'd5, 3'd6, 3'd3},
        '{3'd4, 3'd7, 3'd6, 3'd3}
    };

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_MACHINE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_128K  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_PG_DIS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_PG_DIS  = 3'd4;

    localparam logic [1:0] SIZE_128K  = 2'd0;
    localparam logic [1:0] SIZE_256K  = 2'd1;
    localparam logic [1:0] SIZE_512K  = 2'd2;
    localparam logic [1:0] SIZE_1024K = 2'd3;

    // Write status codes
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_MAIN   = 2'd1,
        ST_EXTRA  = 2'd2,
        ST_LOCKED = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] ram_size;
        logic       alt_machine;
        logic       force_128k;
        logic       rom_pg_dis;
        logic       ram_pg_dis;
    } t_cfg;

    typedef struct packed {
        logic    main_take;
        logic    extra_take;
        t_status status;
    } t_dec;

    // True when the 128K force bit overrides 1024K banking
    function automatic logic force_on(input t_cfg cfg);
        force_on = cfg.alt_machine && (cfg.ram_size == SIZE_1024K) && cfg.force_128k;
    endfunction

    // RAM bank for slot three from a main port value
    function automatic logic [BANK_W-1:0] high_ram_bank(input logic [7:0] m, input t_cfg cfg);
        logic [BANK_W-1:0] b;
        b = {3'b000, m[2:0]};
        if (cfg.ram_size >= SIZE_256K) b[3] = m[6];
        if (cfg.ram_size >= SIZE_512K) b[4] = m[7];
        if (cfg.ram_size == SIZE_1024K) b[5] = m[5];
        if (force_on(cfg)) b[5:3] = 3'b000;
        high_ram_bank = b & BANK_W'(RAM_BANKS - 1);
    endfunction

endpackage

/* design/bmp_decode.sv */
// ----------------------------------------------------------------------------
// bmp_decode
// Port address decode and lock check for one write beat.
// ----------------------------------------------------------------------------
module bmp_decode import bmp_pkg::*; (
    input  logic [15:0] i_port_address,
    input  logic [7:0]  i_main_reg,
    input  t_cfg        i_cfg,
    output t_dec        o_dec
);

    logic w_main_hit;
    logic w_extra_hit;
    logic w_main_open;

    assign w_main_hit  = (i_port_address & MAIN_MASK) == MAIN_MATCH;
    assign w_extra_hit = (i_port_address & EXTRA_MASK) == EXTRA_MATCH;

    // Bit five is a bank bit in 1024K mode unless the force bit applies
    assign w_main_open = ((i_cfg.ram_size == SIZE_1024K) && !force_on(i_cfg))
                         || !i_main_reg[5];

    // Resolve status
    always_comb begin
        o_dec = '{main_take: 1'b0, extra_take: 1'b0, status: ST_NONE};
        if (w_main_hit) begin
            if (w_main_open) begin
                o_dec.main_take = 1'b1;
                o_dec.status    = ST_MAIN;
            end else begin
                o_dec.status = ST_LOCKED;
            end
        end else if (w_extra_hit) begin
            if (!i_main_reg[5]) begin
                o_dec.extra_take = 1'b1;
                o_dec.status     = ST_EXTRA;
            end else begin
                o_dec.status = ST_LOCKED;
            end
        end
    end

endmodule

/* design/bmp_map.sv */
// ----------------------------------------------------------------------------
// bmp_map
// Paging state: both port registers, the four slot banks and the ROM flag.
// Updates once per advanced beat; the registers double as the result.
// ----------------------------------------------------------------------------
module bmp_map import bmp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_dec              i_dec,
    input  logic [7:0]        i_data,
    input  t_cfg              i_cfg,
    output logic [7:0]        o_main_reg,
    output logic [7:0]        o_extra_reg,
    output logic              o_slot0_is_rom,
    output logic [BANK_W-1:0] o_slot0_bank,
    output logic [BANK_W-1:0] o_slot1_bank,
    output logic [BANK_W-1:0] o_slot2_bank,
    output logic [BANK_W-1:0] o_slot3_bank
);

    logic [7:0]        r_main, n_main;
    logic [7:0]        r_extra, n_extra;
    logic [BANK_W-1:0] r_slot [4];
    logic [BANK_W-1:0] n_slot [4];
    logic              r_rom, n_rom;

    // Compute next mapping
    always_comb begin
        n_main  = r_main;
        n_extra = r_extra;
        n_slot  = r_slot;
        n_rom   = r_rom;
        if (i_dec.main_take) begin
            n_main = i_data;
            // in all-RAM mode keep the mapping
            if (!r_extra[0]) begin
                if (!i_cfg.ram_pg_dis) n_slot[3] = high_ram_bank(i_data, i_cfg);
                if (!i_cfg.rom_pg_dis) begin
                    n_slot[0] = {4'b0000, r_extra[2], i_data[4]};
                    n_rom     = 1'b1;
                end
            end
        end else if (i_dec.extra_take) begin
            n_extra = i_data;
            if (i_data[0]) begin
                // enter an all-RAM layout
                for (int s = 0; s < 4; s++) begin
                    n_slot[s] = {3'b000, ALLRAM[i_data[2:1]][s]};
                end
                n_rom = 1'b0;
            end else begin
                // leave all-RAM mode: restore normal mapping
                if (r_extra[0]) begin
                    n_slot[0] = SLOT0_RESET;
                    n_slot[1] = SLOT1_RESET;
                    n_slot[2] = SLOT2_RESET;
                    n_slot[3] = SLOT3_RESET;
                    n_rom     = 1'b1;
                    if (!i_cfg.ram_pg_dis) n_slot[3] = high_ram_bank(r_main, i_cfg);
                end
                if (!i_cfg.rom_pg_dis) begin
                    n_slot[0] = {4'b0000, i_data[2], r_main[4]};
                    n_rom     = 1'b1;
                end
            end
        end
    end

    // Hold state unless a beat advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main    <= '0;
            r_extra   <= '0;
            r_slot[0] <= SLOT0_RESET;
            r_slot[1] <= SLOT1_RESET;
            r_slot[2] <= SLOT2_RESET;
            r_slot[3] <= SLOT3_RESET;
            r_rom     <= 1'b1;
        end else if (i_adv) begin
            r_main  <= n_main;
            r_extra <= n_extra;
            r_slot  <= n_slot;
            r_rom   <= n_rom;
        end
    end

    assign o_main_reg     = r_main;
    assign o_extra_reg    = r_extra;
    assign o_slot0_is_rom = r_rom;
    assign o_slot0_bank   = r_slot[0];
    assign o_slot1_bank   = r_slot[1];
    assign o_slot2_bank   = r_slot[2];
    assign o_slot3_bank   = r_slot[3];

endmodule

/* design/banked_memory_paging_unit.sv */
// From input beat to result valid: input register, then paging state and result update.
// Throughput: one port write per cycle while the result side is not stalled; the paging state update sets the pace.
// Stalls on the result side hold the input register; one beat waits per side.
// Reset (synchronous, active low): ports zero, slots ROM 0 / 5 / 2 / 0,
// configuration zero, no beats pending.
// ----------------------------------------------------------------------------
// banked_memory_paging_unit
// Decodes paging port writes and reports the bank mapped in each 16 KB slot,
// the screen bank, both port values and a status code for every write.
// ----------------------------------------------------------------------------
module banked_memory_paging_unit import bmp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_port_address,
    input  logic [7:0]            i_write_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_slot0_is_rom,
    output logic [BANK_W-1:0]     o_slot0_bank,
    output logic [BANK_W-1:0]     o_slot1_bank,
    output logic [BANK_W-1:0]     o_slot2_bank,
    output logic [BANK_W-1:0]     o_slot3_bank,
    output logic [2:0]            o_screen_bank,
    output logic [7:0]            o_main_port_value,
    output logic [7:0]            o_extra_port_value,
    output logic [1:0]            o_write_status
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic        r_out_valid;
    t_status     r_status;
    logic        w_adv;
    t_dec        w_dec;
    logic [7:0]  w_main;
    logic [7:0]  w_extra;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAM_SIZE:    r_cfg.ram_size    <= i_cfg_wdata[1:0];
                CFG_ALT_MACHINE: r_cfg.alt_machine <= i_cfg_wdata[0];
                CFG_FORCE_128K:  r_cfg.force_128k  <= i_cfg_wdata[0];
                CFG_ROM_PG_DIS:  r_cfg.rom_pg_dis  <= i_cfg_wdata[0];
                CFG_RAM_PG_DIS:  r_cfg.ram_pg_dis  <= i_cfg_wdata[0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // Advance the held beat when the result slot is free or being taken
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_addr <= i_port_address;
            r_data <= i_write_data;
        end
    end

    bmp_decode u_decode (
        .i_port_address (r_addr),
        .i_main_reg     (w_main),
        .i_cfg          (r_cfg),
        .o_dec          (w_dec)
    );

    bmp_map u_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_dec          (w_dec),
        .i_data         (r_data),
        .i_cfg          (r_cfg),
        .o_main_reg     (w_main),
        .o_extra_reg    (w_extra),
        .o_slot0_is_rom (o_slot0_is_rom),
        .o_slot0_bank   (o_slot0_bank),
        .o_slot1_bank   (o_slot1_bank),
        .o_slot2_bank   (o_slot2_bank),
        .o_slot3_bank   (o_slot3_bank)
    );

    // Result valid and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_status    <= ST_NONE;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
            r_status    <= w_dec.status;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_write_status     = r_status;
    assign o_main_port_value  = w_main;
    assign o_extra_port_value = w_extra;
    assign o_screen_bank      = w_main[3] ? SCREEN_SHADOW : SCREEN_NORMAL;

`ifndef ASSERT_OFF
    a_locked_keeps_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_dec.status == ST_LOCKED) |=>
        (o_main_port_value == $past(o_main_port_value)
         && o_extra_port_value == $past(o_extra_port_value)))
        else $error("locked write changed a port value");

    a_hold_without_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(o_main_port_value) && $stable(o_extra_port_value)
                    && $stable(o_slot3_bank) && $stable(o_slot0_is_rom)))
        else $error("paging state changed without an advanced beat");

    a_allram_no_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_extra_port_value[0] |-> !o_slot0_is_rom)
        else $error("ROM mapped in slot zero during all-RAM mode");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_adv)
        else $error("beat advanced over a pending result");
`endif

endmodule
